// ===== rtl/aflt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive flow limit table package
// Shared constants, codes and types for the throttle table.
// ----------------------------------------------------------------------------
package aflt_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 16;
   localparam logic [15:0] ZERO_BELOW = 16'd50;
   localparam logic [16:0] UP_MARGIN = 17'd10;
   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [2:0] {
      FUNC_KEEP  = 3'd0,
      FUNC_DOWN  = 3'd1,
      FUNC_UP    = 3'd2,
      FUNC_CHECK = 3'd3,
      FUNC_OVFL  = 3'd4,
      FUNC_CLEAR = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      CSR_MAX_THR   = 3'd0,
      CSR_UP_INTV   = 3'd1,
      CSR_DOWN_INTV = 3'd2,
      CSR_UP_FACT   = 3'd3,
      CSR_DOWN_FACT = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic        start;
      logic [30:0] dividend;
      logic [15:0] divisor;
   } mod_req_type;

endpackage

// ===== rtl/aflt_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive flow limit table remainder unit
// Restoring bit-serial remainder of a 31-bit value by a 16-bit divisor.
// ----------------------------------------------------------------------------
module aflt_mod (
   input  logic               clock,
   input  logic               reset,
   input  aflt_pkg::mod_req_type req,
   output logic               done,
   output logic [15:0]        remainder
);
   import aflt_pkg::*;

   logic [30:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quot_ff[30]};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
         cnt_in  = 5'd30;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[29:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[15:0];
endmodule

// ===== rtl/adaptive_flow_limit_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive flow limit table
// Throttle entries keyed by server and namespace, held in one memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A clear drops all
// valid bits and answers without a scan; any other item has the block scan
// the entry memory one entry a cycle for a key match and the lowest free
// entry, settle the matched entry, work out the new threshold and, for a
// keep, a raise or a lower, write it back. Busy stays high through the scan,
// read and response states, through the calculation state where the item
// gets that far, and through the multiply state when a raise or lower goes
// ahead. An overflow query with a threshold between zero and the maximum also
// runs the bit-serial remainder unit, so busy stays high through its wait.
// The result is shown for one cycle with rsp_valid in the cycle in which busy
// falls, and the next item can be taken at the edge that ends it. The receiver
// cannot stall. Reset clears the valid bits and restores the state, flags and
// settings; the key and data memory needs no clearing. Configuration writes
// are taken at any time and are meant for when the block is idle.
// ----------------------------------------------------------------------------
module adaptive_flow_limit_table #(
   parameter int unsigned ENTRIES = aflt_pkg::ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_server_key,
   input  logic [15:0] req_namespace_key,
   input  logic [31:0] req_now_seconds,
   input  logic [30:0] req_random_value,
   output logic        rsp_valid,
   output logic        rsp_answer,
   output logic        rsp_table_full,
   output logic [15:0] rsp_threshold_now,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [aflt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);
   import aflt_pkg::*;

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SCAN  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_CALC  = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_MOD   = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   logic [127:0] mem [ENTRIES];
   logic [127:0] rd_ff;
   logic [IW-1:0] rd_addr;
   logic         wr_en;
   logic [IW-1:0] wr_addr;
   logic [127:0] wr_data;

   state_type   state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [15:0] max_ff, upi_ff, dni_ff;
   logic [7:0]  upf_ff, dnf_ff;
   logic [2:0]  func_ff;
   logic [63:0] srv_ff;
   logic [15:0] ns_ff;
   logic [31:0] now_ff;
   logic [30:0] rnd_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        rvld_ff, rvld_in;
   logic [IW-1:0] ridx_ff, ridx_in;
   logic        hit_ff, hit_in;
   logic [IW-1:0] hidx_ff, hidx_in;
   logic        free_ff, free_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic [15:0] thr_ff, thr_in;
   logic [31:0] last_ff, last_in;
   logic [23:0] prod_ff, prod_in;
   logic        ans_ff, ans_in, full_ff, full_in;
   logic [15:0] out_ff, out_in;
   logic        rsp_ff, rsp_in;
   mod_req_type mreq;
   logic        mdone;
   logic [15:0] mrem;
   logic [31:0] elapsed;
   logic [IW-1:0] slot;
   logic        slot_ok;

   aflt_mod u_mod (.clock(clock), .reset(reset), .req(mreq), .done(mdone),
      .remainder(mrem));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign elapsed = now_ff - last_ff;
   assign slot    = hit_ff ? hidx_ff : fidx_ff;
   assign slot_ok = hit_ff || free_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      rvld_in  = 1'b0;
      ridx_in  = ridx_ff;
      hit_in   = hit_ff;
      hidx_in  = hidx_ff;
      free_in  = free_ff;
      fidx_in  = fidx_ff;
      thr_in   = thr_ff;
      last_in  = last_ff;
      prod_in  = prod_ff;
      ans_in   = ans_ff;
      full_in  = full_ff;
      out_in   = out_ff;
      rsp_in   = 1'b0;
      rd_addr  = cnt_ff[IW-1:0];
      wr_en    = 1'b0;
      wr_addr  = slot;
      wr_data  = {srv_ff, ns_ff, thr_ff, last_ff};
      mreq.start    = 1'b0;
      mreq.dividend = rnd_ff;
      mreq.divisor  = max_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cnt_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               ans_in  = 1'b0;
               full_in = 1'b0;
               out_in  = '0;
               if (req_func == FUNC_CLEAR) begin
                  valid_in = '0;
                  ans_in   = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff < CW'(ENTRIES)) begin
               rvld_in = 1'b1;
               ridx_in = cnt_ff[IW-1:0];
               cnt_in  = cnt_ff + CW'(1);
            end
            if (rvld_ff) begin
               if (valid_ff[ridx_ff]) begin
                  if (!hit_ff && rd_ff[127:64] == srv_ff && rd_ff[63:48] == ns_ff) begin
                     hit_in  = 1'b1;
                     hidx_in = ridx_ff;
                     thr_in  = rd_ff[47:32];
                     last_in = rd_ff[31:0];
                  end
               end else if (!free_ff) begin
                  free_in = 1'b1;
                  fidx_in = ridx_ff;
               end
            end else if (cnt_ff == CW'(ENTRIES)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (!hit_ff) begin
               thr_in  = '0;
               last_in = '0;
            end
            state_in = ST_CALC;
            if (func_ff > 3'(FUNC_UP) && !hit_ff) begin
               state_in = ST_RESP;
            end else if (func_ff <= 3'(FUNC_UP) && !slot_ok) begin
               full_in  = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_CALC: begin
            out_in   = thr_ff;
            state_in = ST_RESP;
            if (func_ff == 3'(FUNC_KEEP)) begin
               ans_in  = 1'b1;
               last_in = now_ff;
               wr_en   = 1'b1;
               wr_data = {srv_ff, ns_ff, thr_ff, now_ff};
               valid_in[slot] = 1'b1;
            end else if (func_ff == 3'(FUNC_DOWN)) begin
               wr_en = 1'b1;
               valid_in[slot] = 1'b1;
               if (elapsed >= {16'd0, dni_ff}) begin
                  prod_in  = thr_ff * (9'd256 - {1'b0, dnf_ff});
                  state_in = ST_MUL;
               end
            end else if (func_ff == 3'(FUNC_UP)) begin
               wr_en = 1'b1;
               valid_in[slot] = 1'b1;
               if (elapsed >= {16'd0, upi_ff}) begin
                  ans_in = 1'b1;
                  if ($signed({1'b0, thr_ff}) < $signed({1'b0, max_ff} - UP_MARGIN)) begin
                     prod_in  = upf_ff * (max_ff - thr_ff);
                     state_in = ST_MUL;
                  end
               end
            end else if (func_ff == 3'(FUNC_CHECK)) begin
               ans_in = elapsed >= {16'd0, dni_ff};
            end else if (func_ff == 3'(FUNC_OVFL)) begin
               if (thr_ff == '0) begin
                  ans_in = 1'b0;
               end else if (thr_ff >= max_ff) begin
                  ans_in = 1'b1;
               end else begin
                  mreq.start = 1'b1;
                  state_in   = ST_MOD;
               end
            end
         end
         ST_MUL: begin
            ans_in   = 1'b1;
            state_in = ST_RESP;
            if (func_ff == 3'(FUNC_DOWN)) begin
               thr_in = (prod_ff[23:8] < ZERO_BELOW) ? 16'd0 : prod_ff[23:8];
            end else begin
               thr_in = thr_ff + prod_ff[23:8];
            end
            out_in  = thr_in;
            wr_en   = 1'b1;
            wr_data = {srv_ff, ns_ff, thr_in, now_ff};
         end
         ST_MOD: begin
            if (mdone) begin
               ans_in   = mrem < thr_ff;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_in   = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == ST_IDLE) begin
         func_ff <= req_func;
         srv_ff  <= req_server_key;
         ns_ff   <= req_namespace_key;
         now_ff  <= req_now_seconds;
         rnd_ff  <= req_random_value;
      end
      ridx_ff <= ridx_in;
      hidx_ff <= hidx_in;
      fidx_ff <= fidx_in;
      thr_ff  <= thr_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
      ans_ff  <= ans_in;
      full_ff <= full_in;
      out_ff  <= out_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rvld_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         rsp_ff   <= 1'b0;
         max_ff   <= 16'd1000;
         upi_ff   <= 16'd60;
         dni_ff   <= 16'd60;
         upf_ff   <= 8'd128;
         dnf_ff   <= 8'd128;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rvld_ff  <= rvld_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
         rsp_ff   <= rsp_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MAX_THR:   max_ff <= csr_data;
               CSR_UP_INTV:   upi_ff <= csr_data;
               CSR_DOWN_INTV: dni_ff <= csr_data;
               CSR_UP_FACT:   upf_ff <= csr_data[7:0];
               CSR_DOWN_FACT: dnf_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_ff;
   assign rsp_answer        = ans_ff;
   assign rsp_table_full    = full_ff;
   assign rsp_threshold_now = out_ff;
endmodule

// ===== rtl/aflt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive flow limit table checker
// Port-level checks on the command and result channels.
// ----------------------------------------------------------------------------
module aflt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_answer,
   input logic        rsp_table_full,
   input logic [15:0] rsp_threshold_now
);
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("item taken without busy");
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result shown twice");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy while result shown");
   a_full_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_answer && rsp_threshold_now == 16'd0)
      else $error("full result carries data");
endmodule

bind adaptive_flow_limit_table aflt_checker u_aflt_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_answer(rsp_answer),
   .rsp_table_full(rsp_table_full), .rsp_threshold_now(rsp_threshold_now)
);
